// File: src/cpss_pkg.sv
package cpss_pkg;

   // Geometry of the scan
   localparam int BASE_PAGE_SHIFT = 12;
   localparam int ADDR_WIDTH      = 64;
   localparam int FRAME_W         = ADDR_WIDTH - BASE_PAGE_SHIFT;
   localparam int LEN_W           = 32 - BASE_PAGE_SHIFT;

   // Queue depths between the parts (powers of two)
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int ODEPTH = 4;
   localparam int OPTR_W = $clog2(ODEPTH);

   // Saturation value of the page count
   localparam logic [30:0] COUNT_MAX = '1;

   // Register map
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_CAP  = CSR_IDX_W'(1);

   // Classified entry, as queued between front and back
   typedef struct packed {
      logic [FRAME_W-1:0] pfn;
      logic [6:0]         pfn_tz;
      logic [LEN_W-1:0]   pages;
      logic               last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_out_type;

   typedef struct packed {
      logic [63:0] start_addr;
      logic [5:0]  shift_cap;
   } cfg_type;

   // Region summary handed from back engine to finisher
   typedef struct packed {
      logic        valid;
      logic [30:0] total;
      logic [6:0]  align;
   } fin_type;

   typedef struct packed {
      logic [30:0] page_count;
      logic [5:0]  page_shift_out;
      logic [30:0] compound_pages;
      logic [4:0]  order;
   } rsp_type;

   // Trailing zero count, 64 for a zero word
   function automatic logic [6:0] tz64(logic [63:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (x[i]) begin
            n = 7'(i);
         end
      end
      return n;
   endfunction

   // Number of significant bits
   function automatic logic [4:0] bitlen31(logic [30:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 31; i++) begin
         if (v[i]) begin
            n = 5'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// File: src/cpss_front.sv
module cpss_front import cpss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [63:0] req_dma_addr,
   input  logic [31:0] req_dma_len,
   input  logic        req_last,
   output logic        req_full,
   input  logic        deq_pop,
   output q_out_type   deq
);

   item_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   item_type             item_in;
   logic                 push_ok;
   logic                 pop_ok;

   // Decode the entry: frame number, its alignment, whole base pages
   always_comb begin
      item_in.pfn    = req_dma_addr[ADDR_WIDTH-1:BASE_PAGE_SHIFT];
      item_in.pfn_tz = tz64(64'(req_dma_addr[ADDR_WIDTH-1:BASE_PAGE_SHIFT]));
      item_in.pages  = req_dma_len[31:BASE_PAGE_SHIFT];
      item_in.last   = req_last;
   end

   // Queue control
   always_comb begin
      req_full  = (count_ff == (QPTR_W+1)'(QDEPTH));
      deq.valid = (count_ff != '0);
      deq.item  = slot_ff[rd_ptr_ff];
      push_ok   = req_push && !req_full;
      pop_ok    = deq_pop && deq.valid;
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// File: src/cpss_back.sv
module cpss_back import cpss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  q_out_type deq,
   output logic      deq_pop,
   input  cfg_type   cfg,
   input  logic      fin_credit,
   output fin_type   fin
);

   logic        fresh_ff, fresh_in;
   logic [63:0] run_pages_ff, run_pages_in;
   logic [63:0] run_end_ff, run_end_in;
   logic [6:0]  align_ff, align_in;
   logic [30:0] total_ff, total_in;

   logic [6:0]  start_tz;
   logic [6:0]  init_align;
   logic [5:0]  cap;
   logic [6:0]  base_align;
   logic [6:0]  run_tz;
   logic [6:0]  t_tz;
   logic [6:0]  align_next;
   logic [63:0] pfn_w;
   logic [63:0] pages_w;
   logic        new_run;
   logic [31:0] sum;
   logic [30:0] total_next;

   // Alignment at the start of a region, capped where a cap applies
   always_comb begin
      start_tz   = tz64(64'(cfg.start_addr[63:BASE_PAGE_SHIFT]));
      cap        = cfg.shift_cap - 6'(BASE_PAGE_SHIFT);
      init_align = start_tz;
      if (cfg.shift_cap != '0 && cfg.shift_cap >= 6'(BASE_PAGE_SHIFT)) begin
         if (7'(cap) < start_tz) begin
            init_align = 7'(cap);
         end
      end
   end

   // Merge or open a run; alignment drops to tz(frame | offset)
   always_comb begin
      base_align = fresh_ff ? init_align : align_ff;
      pfn_w      = 64'(deq.item.pfn);
      pages_w    = 64'(deq.item.pages);
      new_run    = fresh_ff || (run_end_ff != pfn_w);
      run_tz     = tz64(run_pages_ff);
      t_tz       = (deq.item.pfn_tz < run_tz) ? deq.item.pfn_tz : run_tz;
      if (new_run) begin
         align_next = (t_tz < base_align) ? t_tz : base_align;
      end else begin
         align_next = base_align;
      end

      sum        = {1'b0, total_ff} + 32'(deq.item.pages);
      total_next = (sum > 32'(COUNT_MAX)) ? COUNT_MAX : sum[30:0];

      // a last entry waits until the finisher has room for its result
      deq_pop = deq.valid && (!deq.item.last || fin_credit);

      fresh_in     = fresh_ff;
      run_pages_in = run_pages_ff;
      run_end_in   = run_end_ff;
      align_in     = align_ff;
      total_in     = total_ff;
      fin.valid    = 1'b0;
      fin.total    = total_next;
      fin.align    = align_next;

      if (deq_pop) begin
         if (new_run) begin
            run_pages_in = pages_w;
            run_end_in   = pfn_w + pages_w;
         end else begin
            run_pages_in = run_pages_ff + pages_w;
            run_end_in   = run_end_ff + pages_w;
         end
         fresh_in = 1'b0;
         align_in = align_next;
         total_in = total_next;
         if (deq.item.last) begin
            fin.valid    = 1'b1;
            fresh_in     = 1'b1;
            run_pages_in = '0;
            align_in     = '0;
            total_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b1;
         run_pages_ff <= '0;
         align_ff     <= '0;
         total_ff     <= '0;
      end else begin
         fresh_ff     <= fresh_in;
         run_pages_ff <= run_pages_in;
         align_ff     <= align_in;
         total_ff     <= total_in;
      end
   end

   // Run end only matters once a run is open
   always_ff @(posedge clock) begin
      run_end_ff <= run_end_in;
   end

endmodule

// File: src/cpss_finish.sv
module cpss_finish import cpss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fin_type     fin,
   output logic        fin_credit,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [30:0] rsp_page_count,
   output logic [5:0]  rsp_page_shift_out,
   output logic [30:0] rsp_compound_pages,
   output logic [4:0]  rsp_order
);

   // Stage one: region summary
   logic        s1_valid_ff;
   logic [30:0] s1_total_ff;
   logic [6:0]  s1_align_ff;
   // Stage two: chosen alignment and order
   logic        s2_valid_ff;
   logic [30:0] s2_total_ff;
   logic [4:0]  s2_m_ff, s2_m_in;
   logic [4:0]  s2_ord_ff, s2_ord_in;

   logic [4:0]  lg;
   logic [31:0] ncont;
   rsp_type     rsp_in;
   rsp_type     rsp_head;

   rsp_type             slot_ff [ODEPTH];
   logic [OPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPTR_W:0]     count_ff, count_in;
   logic [OPTR_W+1:0]   committed;
   logic                pop_ok;

   // Ceiling log2 of the count, then clip the alignment to it
   always_comb begin
      lg = (s1_total_ff == '0) ? 5'd0 : bitlen31(s1_total_ff - 31'd1);
      if (s1_align_ff < 7'(lg)) begin
         s2_m_in = s1_align_ff[4:0];
      end else begin
         s2_m_in = lg;
      end
      s2_ord_in = lg - s2_m_in;
   end

   // Compound pages, count rounded up
   always_comb begin
      ncont = (32'(s2_total_ff) + ((32'd1 << s2_m_ff) - 32'd1)) >> s2_m_ff;
      rsp_in.page_count     = s2_total_ff;
      rsp_in.page_shift_out = 6'(BASE_PAGE_SHIFT) + 6'(s2_m_ff);
      rsp_in.compound_pages = ncont[30:0];
      rsp_in.order          = s2_ord_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= fin.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_total_ff <= fin.total;
      s1_align_ff <= fin.align;
      s2_total_ff <= s1_total_ff;
      s2_m_ff     <= s2_m_in;
      s2_ord_ff   <= s2_ord_in;
   end

   // Result queue; room is reserved for everything in flight
   always_comb begin
      committed  = (OPTR_W+2)'(count_ff) + (OPTR_W+2)'(s1_valid_ff)
                   + (OPTR_W+2)'(s2_valid_ff);
      fin_credit = (committed < (OPTR_W+2)'(ODEPTH));
      rsp_empty  = (count_ff == '0);
      pop_ok     = rsp_pop && !rsp_empty;
      wr_ptr_in  = s2_valid_ff ? wr_ptr_ff + OPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop_ok ? rd_ptr_ff + OPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + (OPTR_W+1)'(s2_valid_ff) - (OPTR_W+1)'(pop_ok);
      rsp_head   = slot_ff[rd_ptr_ff];
      rsp_page_count     = rsp_head.page_count;
      rsp_page_shift_out = rsp_head.page_shift_out;
      rsp_compound_pages = rsp_head.compound_pages;
      rsp_order          = rsp_head.order;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         slot_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// File: src/contiguous_page_size_scan_unit.sv
// Largest page size scan over the scatter-gather entries of one DMA region.
// Push one entry (address, byte length, last mark) per cycle; entries are
// counted in 4 KiB base pages and physically adjacent ones merge into runs.
// On the last entry one result is queued: total pages (saturating), chosen
// page shift, compound page count and order; the block is then ready for the
// next region. Sustained rate is one entry per clock, set by the run merge
// and alignment update in the back engine, which finishes an entry per cycle
// while the finisher has room for a last entry's result. A result reaches the
// result queue after its last entry passes the front queue and a two-stage
// finisher; the finisher holds up a last entry only when its four-deep result
// queue, counting the results still in its two stages, has no room.
// Write start_addr (index 0) and the page shift cap (index 1) between
// regions; the configuration port is always ready.
module contiguous_page_size_scan_unit import cpss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [63:0]          req_dma_addr,
   input  logic [31:0]          req_dma_len,
   input  logic                 req_last,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [30:0]          rsp_page_count,
   output logic [5:0]           rsp_page_shift_out,
   output logic [30:0]          rsp_compound_pages,
   output logic [4:0]           rsp_order,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   logic [63:0] start_addr_ff;
   logic [5:0]  shift_cap_ff;
   cfg_type     cfg;
   q_out_type   deq;
   logic        deq_pop;
   fin_type     fin;
   logic        fin_credit;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         shift_cap_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_ADDR: start_addr_ff <= csr_wdata;
            CSR_SHIFT_CAP:  shift_cap_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.start_addr = start_addr_ff;
      cfg.shift_cap  = shift_cap_ff;
   end

   cpss_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_dma_addr (req_dma_addr),
      .req_dma_len  (req_dma_len),
      .req_last     (req_last),
      .req_full     (req_full),
      .deq_pop      (deq_pop),
      .deq          (deq)
   );

   cpss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deq        (deq),
      .deq_pop    (deq_pop),
      .cfg        (cfg),
      .fin_credit (fin_credit),
      .fin        (fin)
   );

   cpss_finish u_finish (
      .clock              (clock),
      .reset              (reset),
      .fin                (fin),
      .fin_credit         (fin_credit),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_page_count     (rsp_page_count),
      .rsp_page_shift_out (rsp_page_shift_out),
      .rsp_compound_pages (rsp_compound_pages),
      .rsp_order          (rsp_order)
   );

endmodule

// File: src/cpss_checker.sv
module cpss_checker import cpss_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [30:0]          rsp_page_count,
   input logic [5:0]           rsp_page_shift_out,
   input logic [30:0]          rsp_compound_pages,
   input logic [4:0]           rsp_order
);

   // Result queue comes out of reset empty and the front queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_page_count)
         && $stable(rsp_compound_pages) && $stable(rsp_page_shift_out)
         && $stable(rsp_order))
      else $error("waiting result changed");

   // Empty region reports the base page and nothing else
   a_empty_region: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_page_count == '0 |->
         rsp_page_shift_out == 6'(BASE_PAGE_SHIFT) && rsp_order == '0
         && rsp_compound_pages == '0)
      else $error("bad result for empty region");

   // Compound pages never exceed base pages, and exist when pages do
   a_compound_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_compound_pages <= rsp_page_count
         && ((rsp_page_count == '0) == (rsp_compound_pages == '0)))
      else $error("compound page count out of bounds");

endmodule

bind contiguous_page_size_scan_unit cpss_checker u_cpss_checker (
   .clock              (clock),
   .reset              (reset),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_page_count     (rsp_page_count),
   .rsp_page_shift_out (rsp_page_shift_out),
   .rsp_compound_pages (rsp_compound_pages),
   .rsp_order          (rsp_order)
);

// File: test/tb_contiguous_page_size_scan_unit.sv
`timescale 1ns / 100ps

module tb_contiguous_page_size_scan_unit import cpss_pkg::*; ();

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_GAP       = 17;
   localparam logic [63:0] PAGE_OFFSET_MASK = (64'd1 << BASE_PAGE_SHIFT) - 64'd1;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic [63:0]          req_dma_addr = '0;
   logic [31:0]          req_dma_len = '0;
   logic                 req_last = 1'b0;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [30:0]          rsp_page_count;
   logic [5:0]           rsp_page_shift_out;
   logic [30:0]          rsp_compound_pages;
   logic [4:0]           rsp_order;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   contiguous_page_size_scan_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_dma_addr       (req_dma_addr),
      .req_dma_len        (req_dma_len),
      .req_last           (req_last),
      .req_full           (req_full),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_page_count     (rsp_page_count),
      .rsp_page_shift_out (rsp_page_shift_out),
      .rsp_compound_pages (rsp_compound_pages),
      .rsp_order          (rsp_order),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Predictor copy of the registers and of the scan state
   logic [63:0] cfg_start_addr = '0;
   logic [5:0]  cfg_max_shift  = '0;
   logic [63:0] scan_frame_base = '1;
   logic [63:0] scan_run_pages  = '0;
   int          scan_align      = 0;
   logic [30:0] scan_total      = '0;
   bit          scan_at_start   = 1'b1;

   rsp_type due_page_sizes[$];

   // Run control and statistics
   bit tx_gaps_on    = 1'b1;
   bit rx_gaps_on    = 1'b1;
   int hold_requests = 0;
   int mismatches    = 0;
   int entries_sent  = 0;
   int regions_checked = 0;
   int cfg_writes    = 0;
   int full_stalls   = 0;
   int cycle_count   = 0;

   function automatic int trailing_zero_bits(input logic [63:0] w);
      int n;
      n = 0;
      if (w == '0) begin
         return 64;
      end
      while (!w[0]) begin
         w = w >> 1;
         n++;
      end
      return n;
   endfunction

   function automatic int pages_log2_up(input logic [30:0] v);
      int n;
      n = 0;
      while (n < 31 && (64'd1 << n) < 64'(v)) begin
         n++;
      end
      return n;
   endfunction

   // Fold one accepted entry into the scan; queue a result on the last one
   function automatic void advance_page_scan(input logic [63:0] addr,
                                             input logic [31:0] len,
                                             input logic last);
      logic [63:0] frame;
      logic [63:0] npages;
      logic [63:0] probe;
      logic [63:0] mask;
      logic [63:0] chunks;
      logic [32:0] sum;
      int          m;
      int          cap;
      int          lg;
      int          ord;
      rsp_type     r;
      frame  = (addr & ({64{1'b1}} >> (64 - ADDR_WIDTH))) >> BASE_PAGE_SHIFT;
      npages = 64'(len >> BASE_PAGE_SHIFT);

      // alignment of a new region comes from the start address and the cap
      if (scan_at_start) begin
         m = trailing_zero_bits(cfg_start_addr >> BASE_PAGE_SHIFT);
         if (cfg_max_shift != '0 && int'(cfg_max_shift) >= BASE_PAGE_SHIFT) begin
            cap = int'(cfg_max_shift) - BASE_PAGE_SHIFT;
            if (cap < m) begin
               m = cap;
            end
         end
         scan_align = m;
      end

      // a break in the frames opens a new run and may lower the alignment
      if (scan_at_start || scan_frame_base + scan_run_pages != frame) begin
         probe = frame | scan_run_pages;
         mask  = (scan_align >= 64) ? {64{1'b1}} : ((64'd1 << scan_align) - 64'd1);
         if ((probe & mask) != '0) begin
            scan_align = trailing_zero_bits(probe);
         end
         scan_frame_base = frame;
         scan_run_pages  = '0;
      end
      scan_at_start = 1'b0;

      scan_run_pages = scan_run_pages + npages;
      sum = 33'(scan_total) + 33'(npages);
      scan_total = (sum > 33'(COUNT_MAX)) ? COUNT_MAX : sum[30:0];

      if (last) begin
         m = 0;
         ord = 0;
         chunks = '0;
         if (scan_total != '0) begin
            lg = pages_log2_up(scan_total);
            m = (scan_align < lg) ? scan_align : lg;
            ord = lg - m;
            chunks = (64'(scan_total) + ((64'd1 << m) - 64'd1)) >> m;
         end
         r.page_count     = scan_total;
         r.page_shift_out = 6'(BASE_PAGE_SHIFT + m);
         r.compound_pages = chunks[30:0];
         r.order          = 5'(ord);
         due_page_sizes.push_back(r);

         scan_frame_base = '1;
         scan_run_pages  = '0;
         scan_align      = 0;
         scan_total      = '0;
         scan_at_start   = 1'b1;
      end
   endfunction

   // Offer one entry; push stays high afterwards so back-to-back items flow
   task automatic send_entry(input logic [63:0] addr, input logic [31:0] len,
                             input logic last);
      int gap;
      gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_dma_addr <= addr;
      req_dma_len  <= len;
      req_last     <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      advance_page_scan(addr, len, last);
      entries_sent++;
   endtask

   // Sender stops until every result is in and the pipeline has emptied
   task automatic wait_results_drained();
      req_push <= 1'b0;
      while (due_page_sizes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers in one burst; valid stays high across the pair
   task automatic program_scan(input logic [63:0] start, input logic [5:0] cap);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_ADDR;
      csr_wdata <= start;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_start_addr = start;
      // junk above the six shift bits is ignored by the block
      csr_index <= CSR_SHIFT_CAP;
      csr_wdata <= ({$urandom, $urandom} & ~64'h3F) | 64'(cap);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_max_shift = cap;
      csr_valid <= 1'b0;
      cfg_writes += 2;
   endtask

   task automatic reconfigure(input logic [63:0] start, input logic [5:0] cap);
      wait_results_drained();
      program_scan(start, cap);
   endtask

   // Random address with exactly tz trailing zero bits
   function automatic logic [63:0] draw_aligned_addr(input int tz);
      logic [63:0] w;
      w = {$urandom, $urandom};
      w = (w >> (tz + 1)) << (tz + 1);
      return w | (64'd1 << tz);
   endfunction

   function automatic logic [31:0] draw_len();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 32'(PAGE_OFFSET_MASK));
         2: return 32'd1 << $urandom_range(BASE_PAGE_SHIFT, 31);
         default: return (32'($urandom_range(1, 64)) << BASE_PAGE_SHIFT) |
                         ($urandom_range(0, 1) ? $urandom_range(0, 32'(PAGE_OFFSET_MASK)) : 0);
      endcase
   endfunction

   function automatic logic [63:0] draw_start_addr();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return draw_aligned_addr($urandom_range(BASE_PAGE_SHIFT, 63));
         4: return draw_aligned_addr($urandom_range(0, BASE_PAGE_SHIFT - 1));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [5:0] draw_cap();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 6'($urandom_range(1, BASE_PAGE_SHIFT - 1));
         2: return 6'(BASE_PAGE_SHIFT);
         3: return 6'd63;
         default: return 6'($urandom_range(BASE_PAGE_SHIFT + 1, 62));
      endcase
   endfunction

   // Well-formed region: mostly adjacent frames, some jumps, last on the end
   task automatic send_region(input int n);
      logic [63:0] addr;
      logic [31:0] len;
      addr = draw_aligned_addr($urandom_range(0, 63));
      for (int k = 0; k < n; k++) begin
         len = draw_len();
         send_entry(addr, len, k == n - 1);
         case ($urandom_range(0, 9))
            0, 1: addr = draw_aligned_addr($urandom_range(0, 63));
            2: addr = {$urandom, $urandom};
            default: addr = (((addr >> BASE_PAGE_SHIFT) + 64'(len >> BASE_PAGE_SHIFT))
                             << BASE_PAGE_SHIFT) | ({$urandom, $urandom} & PAGE_OFFSET_MASK);
         endcase
      end
   endtask

   // Result side: random pauses, long holds on request, checks every item
   task automatic check_page_result();
      rsp_type want;
      if (due_page_sizes.size() == 0) begin
         $error("unexpected result: page_count %0d page_shift_out %0d",
                rsp_page_count, rsp_page_shift_out);
         mismatches++;
      end else begin
         want = due_page_sizes.pop_front();
         if (rsp_page_count !== want.page_count) begin
            $error("page_count expected %0d got %0d", want.page_count, rsp_page_count);
            mismatches++;
         end
         if (rsp_page_shift_out !== want.page_shift_out) begin
            $error("page_shift_out expected %0d got %0d",
                   want.page_shift_out, rsp_page_shift_out);
            mismatches++;
         end
         if (rsp_compound_pages !== want.compound_pages) begin
            $error("compound_pages expected %0d got %0d",
                   want.compound_pages, rsp_compound_pages);
            mismatches++;
         end
         if (rsp_order !== want.order) begin
            $error("order expected %0d got %0d", want.order, rsp_order);
            mismatches++;
         end
         regions_checked++;
      end
   endtask

   initial begin : result_sink
      int pause;
      int holds_done;
      holds_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         pause = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (pause > 0) begin
            rsp_pop <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_page_result();
      end
   end

   // Cycle count, input stall count and the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_push && req_full) begin
         full_stalls <= full_stalls + 1;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_page_sizes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Regions with no whole page
   task automatic test_empty_region();
      reconfigure('0, '0);
      send_entry('0, '0, 1'b1);
      send_entry(64'h123, 32'(PAGE_OFFSET_MASK), 1'b1);
   endtask

   // Zero start frame gives full alignment; only a zero probe keeps it
   task automatic test_alignment_64();
      reconfigure('0, '0);
      send_entry('0, 32'h8000_0000, 1'b0);
      send_entry(64'h8000_0000, 32'h8000_0000, 1'b1);
      send_entry(64'h1000, 32'h1000, 1'b1);
   endtask

   // Cap below the base page, at it, in between and at the top
   task automatic test_start_and_cap();
      logic [5:0] caps [4] = '{6'd5, 6'd12, 6'd20, 6'd63};
      foreach (caps[i]) begin
         reconfigure(64'h0000_0040_0000_0000, caps[i]);
         send_entry(64'h0000_0100_0000_0000, 32'hFFFF_F000, 1'b1);
      end
      reconfigure('1, 6'd63);
      send_entry(64'h0000_0100_0000_0000, 32'hFFFF_F000, 1'b1);
   endtask

   // Field extremes, then a run broken at an unaligned frame and offset
   task automatic test_field_extremes();
      reconfigure('0, '0);
      send_entry('1, '1, 1'b0);
      send_entry('0, '0, 1'b0);
      send_entry(64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_F000, 1'b1);
      send_entry(64'h1_0000, 32'h4000, 1'b0);
      send_entry(64'h1_4000, 32'h2000, 1'b0);
      send_entry(64'h2_3000, 32'h1000, 1'b0);
      send_entry(64'h4_0000, 32'h4_0000, 1'b1);
   endtask

   // Receiver holds off so the block fills and pushes back, then the
   // sender waits for every result before carrying on
   task automatic test_result_backpressure();
      reconfigure(draw_start_addr(), draw_cap());
      tx_gaps_on = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (48) send_region($urandom_range(1, 2));
      wait_results_drained();
      tx_gaps_on = 1'b1;
      repeat (12) send_region($urandom_range(1, 3));
   endtask

   // Phases of random regions and noise, new register values per phase
   task automatic test_random_regions(input int goal);
      int first;
      int phase_end;
      first = entries_sent;
      while (entries_sent - first < goal) begin
         reconfigure(draw_start_addr(), draw_cap());
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on <= ($urandom_range(0, 3) != 0);
         phase_end = entries_sent + $urandom_range(30, 90);
         while (entries_sent < phase_end) begin
            if ($urandom_range(0, 4) != 0) begin
               send_region($urandom_range(1, 8));
            end else begin
               send_entry({$urandom, $urandom}, $urandom, $urandom_range(0, 3) == 0);
            end
         end
         // close a region left open by noise
         if (!scan_at_start) begin
            send_entry({$urandom, $urandom}, draw_len(), 1'b1);
         end
      end
      tx_gaps_on = 1'b1;
      rx_gaps_on <= 1'b1;
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_region();
      test_alignment_64();
      test_start_and_cap();
      test_field_extremes();
      test_result_backpressure();
      test_random_regions(900);
      wait_results_drained();
      $display("Checked %0d regions from %0d entries under %0d register writes",
               regions_checked, entries_sent, cfg_writes);
      $display("Input held off by full on %0d cycles, %0d cycles in all",
               full_stalls, cycle_count);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
